// ----- rtl/clt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the consensus log table
// Request and status codes, field widths and the stored entry record.
// ----------------------------------------------------------------------------
package clt_pkg;
  localparam int unsigned WideW = 64;
  localparam int unsigned FieldW = 63;
  localparam int unsigned SizeW = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned LogLimitBase = 1000;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_COMMIT = 3'd1;
  localparam logic [2:0] REQ_APPLY = 3'd2;
  localparam logic [2:0] REQ_GET = 3'd3;
  localparam logic [2:0] REQ_REPL = 3'd4;
  localparam logic [2:0] REQ_CLEAN = 3'd5;
  localparam logic [2:0] REQ_RESET = 3'd6;
  localparam logic [2:0] REQ_TOTALS = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_COMMITTED = 3'd4;

  // One stored entry: index, term, time, size, committed, applied.
  typedef struct packed {
    logic [WideW-1:0] idx;
    logic [FieldW-1:0] term;
    logic [FieldW-1:0] tstamp;
    logic [SizeW-1:0] size;
    logic committed;
    logic applied;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
endpackage
`default_nettype wire

// ----- rtl/consensus_log_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// consensus_log_table: bounded ordered log of consensus entries
// Append, commit, apply, get, replicate count, cleanup, counter reset and
// totals read over a log held in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Handshake
//  --------+-------------------------------+------------------------------
//  in      | in_req_type .. in_time_now    | in_valid / in_ready
//  out     | out_status .. out_count_value | out_valid / out_ready
//  cfg     | cfg_we, cfg_data              | write enable, no wait
//
// Append, reset and totals skip the scan and go straight to a result word.
// Commit, apply and get scan the log slot by slot (a read through the RAM's
// single read port, then a compare of the returned word) and stop at the
// matching index. Replicate and cleanup walk every held slot; cleanup
// writes the compacted entry back through the write port behind the read.
// Reset puts the counters at zero; the RAM needs no clearing since only
// slots below entry_count are read.
// A stalled result word holds the block: no new word is taken until it leaves.
module consensus_log_table
  import clt_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [FieldW-1:0] in_term,
  input  wire logic [SizeW-1:0]  in_payload_size,
  input  wire logic [FieldW-1:0] in_target_index,
  input  wire logic [FieldW-1:0] in_time_now,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [FieldW-1:0]      out_entry_index,
  output logic [FieldW-1:0]      out_entry_term,
  output logic [FieldW-1:0]      out_entry_time,
  output logic [SizeW-1:0]       out_entry_size,
  output logic                   out_entry_committed,
  output logic                   out_entry_applied,
  output logic [CountW-1:0]      out_log_count,
  output logic [FieldW-1:0]      out_newest_index,
  output logic [FieldW-1:0]      out_committed_mark,
  output logic [FieldW-1:0]      out_applied_mark,
  output logic [FieldW-1:0]      out_count_value,
  input  wire logic              cfg_we,
  input  wire logic [SizeW-1:0]  cfg_data
);
  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned LogLimit = (LogLimitBase < LOG_DEPTH) ? LogLimitBase : LOG_DEPTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] req_r, req_nxt;
  logic [FieldW-1:0] term_r, term_nxt, time_r, time_nxt, tgt_r, tgt_nxt;
  logic [SizeW-1:0] psize_r, psize_nxt, max_size_r, max_size_nxt;
  logic [CW-1:0] count_r, count_nxt, rd_r, rd_nxt, wr_r, wr_nxt, chk_r, chk_nxt;
  logic [WideW-1:0] last_r, last_nxt, hcommit_r, hcommit_nxt, happl_r, happl_nxt;
  logic [WideW-1:0] rtot_r, rtot_nxt, ctot_r, ctot_nxt, atot_r, atot_nxt;
  logic [WideW-1:0] acc_r, acc_nxt;
  logic [2:0] ostat_r, ostat_nxt;
  entry_t oent_r, oent_nxt;
  logic ovalid_r, ovalid_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  clt_ram #(.WIDTH(EntryW), .DEPTH(LOG_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [WideW-1:0] tgt_w;
  assign tgt_w = {1'b0, tgt_r};

  // The sequencer reads slot rd_r each scan cycle; the word returns in the next
  // cycle and is judged while chk_r names its slot.
  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    term_nxt = term_r;
    time_nxt = time_r;
    tgt_nxt = tgt_r;
    psize_nxt = psize_r;
    max_size_nxt = cfg_we ? cfg_data : max_size_r;
    count_nxt = count_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    chk_nxt = chk_r;
    last_nxt = last_r;
    hcommit_nxt = hcommit_r;
    happl_nxt = happl_r;
    rtot_nxt = rtot_r;
    ctot_nxt = ctot_r;
    atot_nxt = atot_r;
    acc_nxt = acc_r;
    ostat_nxt = ostat_r;
    oent_nxt = oent_r;
    ovalid_nxt = ovalid_r;
    ram_we = 1'b0;
    ram_waddr = wr_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = rd_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;
          term_nxt = in_term;
          time_nxt = in_time_now;
          tgt_nxt = in_target_index;
          psize_nxt = in_payload_size;
          rd_nxt = '0;
          wr_nxt = '0;
          acc_nxt = '0;
          ostat_nxt = ST_OK;
          oent_nxt = '0;
          if (in_req_type == REQ_APPEND || in_req_type == REQ_RESET ||
              in_req_type == REQ_TOTALS) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue a read; the returned word is judged in the next cycle.
        if (rd_r < count_r) begin
          ram_raddr = rd_r[AW-1:0];
          rd_nxt = rd_r + 1'b1;
          chk_nxt = rd_r;
          state_nxt = S_EVAL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EVAL: begin
        state_nxt = S_SCAN;
        case (req_r)
          REQ_COMMIT, REQ_APPLY, REQ_GET: begin
            if (ram_rdata.idx == tgt_w) begin
              state_nxt = S_DONE;
              wr_nxt = chk_r;
              oent_nxt = ram_rdata;
              acc_nxt = 64'd1;
            end
          end
          REQ_REPL: begin
            if (ram_rdata.idx >= tgt_w) begin
              acc_nxt = acc_r + 1'b1;
            end
          end
          REQ_CLEAN: begin
            if (ram_rdata.idx < tgt_w) begin
              acc_nxt = acc_r + 1'b1;
            end else begin
              ram_we = (wr_r != chk_r);
              ram_waddr = wr_r[AW-1:0];
              ram_wdata = ram_rdata;
              wr_nxt = wr_r + 1'b1;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        state_nxt = S_OUT;
        ovalid_nxt = 1'b1;
        case (req_r)
          REQ_APPEND: begin
            if (psize_r > max_size_r) begin
              ostat_nxt = ST_TOO_LARGE;
            end else if (count_r >= CW'(LogLimit)) begin
              ostat_nxt = ST_FULL;
            end else begin
              last_nxt = last_r + 1'b1;
              ram_we = 1'b1;
              ram_waddr = count_r[AW-1:0];
              ram_wdata = '{idx: last_r + 1'b1, term: term_r, tstamp: time_r,
                            size: psize_r, committed: 1'b0, applied: 1'b0};
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_COMMIT: begin
            if (acc_r == '0) begin
              ostat_nxt = ST_NOT_FOUND;
            end else begin
              ram_we = 1'b1;
              ram_waddr = wr_r[AW-1:0];
              ram_wdata = oent_r;
              ram_wdata.committed = 1'b1;
              if (tgt_w > hcommit_r) begin
                hcommit_nxt = tgt_w;
              end
              ctot_nxt = ctot_r + 1'b1;
            end
            oent_nxt = '0;
          end
          REQ_APPLY: begin
            if (acc_r == '0) begin
              ostat_nxt = ST_NOT_FOUND;
            end else if (!oent_r.committed) begin
              ostat_nxt = ST_NOT_COMMITTED;
            end else begin
              ram_we = 1'b1;
              ram_waddr = wr_r[AW-1:0];
              ram_wdata = oent_r;
              ram_wdata.applied = 1'b1;
              if (tgt_w > happl_r) begin
                happl_nxt = tgt_w;
              end
              atot_nxt = atot_r + 1'b1;
            end
            oent_nxt = '0;
          end
          REQ_GET: begin
            if (acc_r == '0) begin
              ostat_nxt = ST_NOT_FOUND;
            end
            acc_nxt = '0;
          end
          REQ_REPL: begin
            rtot_nxt = rtot_r + acc_r;
          end
          REQ_CLEAN: begin
            count_nxt = wr_r;
          end
          REQ_RESET: begin
            count_nxt = '0;
            last_nxt = '0;
            hcommit_nxt = '0;
            happl_nxt = '0;
            rtot_nxt = '0;
            ctot_nxt = '0;
            atot_nxt = '0;
          end
          default: begin
            if (tgt_w == 64'd0) begin
              acc_nxt = rtot_r;
            end else if (tgt_w == 64'd1) begin
              acc_nxt = ctot_r;
            end else if (tgt_w == 64'd2) begin
              acc_nxt = atot_r;
            end else begin
              acc_nxt = '0;
            end
          end
        endcase
        if (req_r == REQ_COMMIT || req_r == REQ_APPLY) begin
          acc_nxt = '0;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_size_r <= SizeW'(1024);
      count_r <= '0;
      last_r <= '0;
      hcommit_r <= '0;
      happl_r <= '0;
      rtot_r <= '0;
      ctot_r <= '0;
      atot_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      max_size_r <= max_size_nxt;
      count_r <= count_nxt;
      last_r <= last_nxt;
      hcommit_r <= hcommit_nxt;
      happl_r <= happl_nxt;
      rtot_r <= rtot_nxt;
      ctot_r <= ctot_nxt;
      atot_r <= atot_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    term_r <= term_nxt;
    time_r <= time_nxt;
    tgt_r <= tgt_nxt;
    psize_r <= psize_nxt;
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    chk_r <= chk_nxt;
    acc_r <= acc_nxt;
    ostat_r <= ostat_nxt;
    oent_r <= oent_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_status = ostat_r;
  assign out_entry_index = oent_r.idx[FieldW-1:0];
  assign out_entry_term = oent_r.term;
  assign out_entry_time = oent_r.tstamp;
  assign out_entry_size = oent_r.size;
  assign out_entry_committed = oent_r.committed;
  assign out_entry_applied = oent_r.applied;
  assign out_log_count = CountW'(count_r);
  assign out_newest_index = last_r[FieldW-1:0];
  assign out_committed_mark = hcommit_r[FieldW-1:0];
  assign out_applied_mark = happl_r[FieldW-1:0];
  assign out_count_value = acc_r[FieldW-1:0];
endmodule
`default_nettype wire

// ----- rtl/clt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module clt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/clt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clt_checker: port-level checks of the consensus log table
// Watches the handshakes and the reported counters over time.
// ----------------------------------------------------------------------------
module clt_checker
  import clt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        out_status,
  input wire logic [CountW-1:0] out_log_count
);
  // One word in flight: no input is taken while a result word waits.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A result word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word dropped or changed");

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NOT_COMMITTED) else $error("bad status");

  // The log never reports more entries than the limit.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_log_count <= CountW'(LogLimitBase)) else $error("count");
endmodule

bind consensus_log_table clt_checker u_clt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_log_count(out_log_count)
);
`default_nettype wire

// ----- bench/clt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clt_monitor: result checker of the consensus log table
// Watches the request, result and register ports, keeps its own copy of the
// log, predicts one result word per request and compares it field by field.
// ----------------------------------------------------------------------------
module clt_monitor
  import clt_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [2:0]        in_req_type,
  input  wire logic [FieldW-1:0] in_term,
  input  wire logic [SizeW-1:0]  in_payload_size,
  input  wire logic [FieldW-1:0] in_target_index,
  input  wire logic [FieldW-1:0] in_time_now,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [2:0]        out_status,
  input  wire logic [FieldW-1:0] out_entry_index,
  input  wire logic [FieldW-1:0] out_entry_term,
  input  wire logic [FieldW-1:0] out_entry_time,
  input  wire logic [SizeW-1:0]  out_entry_size,
  input  wire logic              out_entry_committed,
  input  wire logic              out_entry_applied,
  input  wire logic [CountW-1:0] out_log_count,
  input  wire logic [FieldW-1:0] out_newest_index,
  input  wire logic [FieldW-1:0] out_committed_mark,
  input  wire logic [FieldW-1:0] out_applied_mark,
  input  wire logic [FieldW-1:0] out_count_value,
  input  wire logic              cfg_we,
  input  wire logic [SizeW-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     words_checked
);

  localparam int unsigned HoldLimit = (LogLimitBase < LOG_DEPTH) ? LogLimitBase : LOG_DEPTH;

  typedef struct {
    logic [2:0]        status;
    logic [FieldW-1:0] eidx;
    logic [FieldW-1:0] eterm;
    logic [FieldW-1:0] etime;
    logic [SizeW-1:0]  esize;
    logic              ecommitted;
    logic              eapplied;
    logic [CountW-1:0] held;
    logic [FieldW-1:0] newest;
    logic [FieldW-1:0] cmark;
    logic [FieldW-1:0] amark;
    logic [FieldW-1:0] cval;
  } log_word_t;

  log_word_t expected_words[$];

  logic [WideW-1:0]  idx_mem [LOG_DEPTH];
  logic [FieldW-1:0] term_mem [LOG_DEPTH];
  logic [FieldW-1:0] time_mem [LOG_DEPTH];
  logic [SizeW-1:0]  size_mem [LOG_DEPTH];
  logic              com_mem [LOG_DEPTH];
  logic              app_mem [LOG_DEPTH];
  int unsigned       held_n;
  logic [WideW-1:0]  newest_q, hi_commit, hi_apply;
  logic [WideW-1:0]  tot_repl, tot_commit, tot_apply;
  logic [SizeW-1:0]  size_limit;
  int                reported;

  function automatic int find_entry(logic [WideW-1:0] t);
    for (int i = 0; i < int'(held_n); i++) begin
      if (idx_mem[i] == t) return i;
    end
    return -1;
  endfunction

  task automatic clear_counters();
    held_n = 0;
    newest_q = '0;
    hi_commit = '0;
    hi_apply = '0;
    tot_repl = '0;
    tot_commit = '0;
    tot_apply = '0;
  endtask

  // Applies one request to the log copy and returns the word it must produce.
  task automatic predict_log_word(input logic [2:0] req, input logic [FieldW-1:0] term,
                                  input logic [SizeW-1:0] psize,
                                  input logic [FieldW-1:0] target,
                                  input logic [FieldW-1:0] tnow, output log_word_t r);
    int s;
    int unsigned w;
    logic [WideW-1:0] t64;
    logic [WideW-1:0] cnt;
    t64 = {1'b0, target};
    cnt = '0;
    r = '{default: '0};
    r.status = ST_OK;
    case (req)
      REQ_APPEND: begin
        if (psize > size_limit) begin
          r.status = ST_TOO_LARGE;
        end else if (held_n >= HoldLimit) begin
          r.status = ST_FULL;
        end else begin
          newest_q = newest_q + 1;
          idx_mem[held_n] = newest_q;
          term_mem[held_n] = term;
          time_mem[held_n] = tnow;
          size_mem[held_n] = psize;
          com_mem[held_n] = 1'b0;
          app_mem[held_n] = 1'b0;
          held_n++;
        end
      end
      REQ_COMMIT: begin
        s = find_entry(t64);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          com_mem[s] = 1'b1;
          if (t64 > hi_commit) hi_commit = t64;
          tot_commit = tot_commit + 1;
        end
      end
      REQ_APPLY: begin
        s = find_entry(t64);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (!com_mem[s]) begin
          r.status = ST_NOT_COMMITTED;
        end else begin
          app_mem[s] = 1'b1;
          if (t64 > hi_apply) hi_apply = t64;
          tot_apply = tot_apply + 1;
        end
      end
      REQ_GET: begin
        s = find_entry(t64);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.eidx = idx_mem[s][FieldW-1:0];
          r.eterm = term_mem[s];
          r.etime = time_mem[s];
          r.esize = size_mem[s];
          r.ecommitted = com_mem[s];
          r.eapplied = app_mem[s];
        end
      end
      REQ_REPL: begin
        for (int i = 0; i < int'(held_n); i++) begin
          if (idx_mem[i] >= t64) cnt = cnt + 1;
        end
        tot_repl = tot_repl + cnt;
      end
      REQ_CLEAN: begin
        // Compaction keeps the survivors in their original order.
        w = 0;
        for (int unsigned i = 0; i < held_n; i++) begin
          if (idx_mem[i] < t64) begin
            cnt = cnt + 1;
          end else begin
            idx_mem[w] = idx_mem[i];
            term_mem[w] = term_mem[i];
            time_mem[w] = time_mem[i];
            size_mem[w] = size_mem[i];
            com_mem[w] = com_mem[i];
            app_mem[w] = app_mem[i];
            w++;
          end
        end
        held_n = w;
      end
      REQ_RESET: begin
        clear_counters();
      end
      default: begin
        if (t64 == 0) cnt = tot_repl;
        else if (t64 == 1) cnt = tot_commit;
        else if (t64 == 2) cnt = tot_apply;
      end
    endcase
    r.held = held_n[CountW-1:0];
    r.newest = newest_q[FieldW-1:0];
    r.cmark = hi_commit[FieldW-1:0];
    r.amark = hi_apply[FieldW-1:0];
    r.cval = cnt[FieldW-1:0];
  endtask

  task automatic check_field(input string name, input logic [WideW-1:0] want,
                             input logic [WideW-1:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (reported < 10) begin
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    log_word_t want;
    log_word_t fresh;
    bit bad;
    if (!rst_n) begin
      clear_counters();
      size_limit = 16'd1024;
      expected_words.delete();
      fail_count = 0;
      words_checked = 0;
      reported = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            $display("%0t result word with nothing expected", $time);
            reported++;
          end
        end else begin
          want = expected_words.pop_front();
          bad = 1'b0;
          check_field("status", want.status, out_status, bad);
          check_field("entry_index", want.eidx, out_entry_index, bad);
          check_field("entry_term", want.eterm, out_entry_term, bad);
          check_field("entry_time", want.etime, out_entry_time, bad);
          check_field("entry_size", want.esize, out_entry_size, bad);
          check_field("entry_committed", want.ecommitted, out_entry_committed, bad);
          check_field("entry_applied", want.eapplied, out_entry_applied, bad);
          check_field("log_count", want.held, out_log_count, bad);
          check_field("newest_index", want.newest, out_newest_index, bad);
          check_field("committed_mark", want.cmark, out_committed_mark, bad);
          check_field("applied_mark", want.amark, out_applied_mark, bad);
          check_field("count_value", want.cval, out_count_value, bad);
          if (bad) fail_count++;
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_log_word(in_req_type, in_term, in_payload_size, in_target_index,
                         in_time_now, fresh);
        expected_words.push_back(fresh);
      end
      if (cfg_we) size_limit = cfg_data;
    end
    pending = expected_words.size();
  end

endmodule

// ----- bench/tb_consensus_log_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_consensus_log_table: regression bench of the consensus log table
// Drives directed and random request words through bursts and gaps, stalls
// the result side on its own pattern, builds, scans and compacts a log once
// and sweeps the payload limit register; a checker module judges every result.
// ----------------------------------------------------------------------------
module tb_consensus_log_table;
  import clt_pkg::*;

  // The slowest correct word scans a full log and then waits out a long
  // receiver stall, so the limit is reckoned generously above that.
  localparam int CycleLimit = 6000000;
  localparam logic [FieldW-1:0] Max63 = {FieldW{1'b1}};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        in_req_type;
  logic [FieldW-1:0] in_term;
  logic [SizeW-1:0]  in_payload_size;
  logic [FieldW-1:0] in_target_index;
  logic [FieldW-1:0] in_time_now;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        out_status;
  logic [FieldW-1:0] out_entry_index;
  logic [FieldW-1:0] out_entry_term;
  logic [FieldW-1:0] out_entry_time;
  logic [SizeW-1:0]  out_entry_size;
  logic              out_entry_committed;
  logic              out_entry_applied;
  logic [CountW-1:0] out_log_count;
  logic [FieldW-1:0] out_newest_index;
  logic [FieldW-1:0] out_committed_mark;
  logic [FieldW-1:0] out_applied_mark;
  logic [FieldW-1:0] out_count_value;
  logic              cfg_we;
  logic [SizeW-1:0]  cfg_data;

  int fail_count;
  int pending;
  int words_checked;
  int cycles;
  int settings_used;

  // Rough mirror of the newest index, used only to aim targets at live entries.
  logic [FieldW-1:0] newest_guess;
  logic [SizeW-1:0]  limit_now;
  int                burst_left;

  consensus_log_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_term            (in_term),
    .in_payload_size    (in_payload_size),
    .in_target_index    (in_target_index),
    .in_time_now        (in_time_now),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_index    (out_entry_index),
    .out_entry_term     (out_entry_term),
    .out_entry_time     (out_entry_time),
    .out_entry_size     (out_entry_size),
    .out_entry_committed(out_entry_committed),
    .out_entry_applied  (out_entry_applied),
    .out_log_count      (out_log_count),
    .out_newest_index   (out_newest_index),
    .out_committed_mark (out_committed_mark),
    .out_applied_mark   (out_applied_mark),
    .out_count_value    (out_count_value),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data)
  );

  clt_monitor u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_term            (in_term),
    .in_payload_size    (in_payload_size),
    .in_target_index    (in_target_index),
    .in_time_now        (in_time_now),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_entry_index    (out_entry_index),
    .out_entry_term     (out_entry_term),
    .out_entry_time     (out_entry_time),
    .out_entry_size     (out_entry_size),
    .out_entry_committed(out_entry_committed),
    .out_entry_applied  (out_entry_applied),
    .out_log_count      (out_log_count),
    .out_newest_index   (out_newest_index),
    .out_committed_mark (out_committed_mark),
    .out_applied_mark   (out_applied_mark),
    .out_count_value    (out_count_value),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .words_checked      (words_checked)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The watchdog ends a hung run with the failing verdict.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver switches at random between three moods: always ready, a coin
  // toss each cycle, or mostly stalled, so back pressure hits every phase.
  int rx_left = 0;
  int rx_mode = 0;
  initial out_ready = 1'b0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [FieldW-1:0] rand63();
    return FieldW'({$urandom, $urandom});
  endfunction

  // Presents one word and returns at the edge that accepts it. Ready is read
  // at the falling edge, where it is settled for the coming rising edge.
  task automatic send_word(input logic [2:0] req, input logic [FieldW-1:0] term,
                           input logic [SizeW-1:0] psize,
                           input logic [FieldW-1:0] target,
                           input logic [FieldW-1:0] tnow);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_term <= term;
    in_payload_size <= psize;
    in_target_index <= target;
    in_time_now <= tnow;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if (req == REQ_APPEND && psize <= limit_now) newest_guess = newest_guess + 1;
    if (req == REQ_RESET) newest_guess = '0;
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Holds the sender until every word in flight has come back.
  task automatic drain();
    idle_gap(1);
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [SizeW-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_now = value;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [FieldW-1:0] pick_target();
    logic [FieldW-1:0] back;
    if ($urandom_range(0, 15) == 0) return rand63();
    back = (newest_guess < 40) ? newest_guess : 40;
    return newest_guess - $urandom_range(0, int'(back)) + ($urandom_range(0, 7) == 0);
  endfunction

  // One random word inside a burst; mostly well formed, aimed at live entries.
  task automatic send_random();
    int pick;
    logic [2:0] req;
    logic [SizeW-1:0] psize;
    logic [FieldW-1:0] target;
    pick = $urandom_range(0, 99);
    if (pick < 30) req = REQ_APPEND;
    else if (pick < 45) req = REQ_COMMIT;
    else if (pick < 60) req = REQ_APPLY;
    else if (pick < 75) req = REQ_GET;
    else if (pick < 80) req = REQ_REPL;
    else if (pick < 88) req = REQ_CLEAN;
    else if (pick < 90) req = REQ_RESET;
    else req = REQ_TOTALS;
    psize = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1100));
    target = pick_target();
    // Cleanup trims close to the head so the log stays short and scans cheap.
    if (req == REQ_CLEAN && $urandom_range(0, 3) != 0)
      target = newest_guess - $urandom_range(0, 10);
    if (req == REQ_TOTALS && $urandom_range(0, 3) != 0) target = FieldW'($urandom_range(0, 3));
    send_word(req, rand63(), psize, target, rand63());
    if (burst_left == 0) begin
      idle_gap($urandom_range(1, 12));
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_APPEND;
    in_term = '0;
    in_payload_size = '0;
    in_target_index = '0;
    in_time_now = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    newest_guess = '0;
    limit_now = 16'd1024;
    burst_left = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words against the reset limit: size extremes, every request,
    // a missing index, applying before commit, each totals selector.
    send_word(REQ_APPEND, '0, 16'd0, '0, '0);
    send_word(REQ_APPEND, Max63, 16'd1024, Max63, Max63);
    send_word(REQ_APPEND, Max63, 16'd1025, '0, '0);
    send_word(REQ_APPEND, '0, 16'hFFFF, '0, '0);
    send_word(REQ_GET, '0, '0, 63'd2, '0);
    send_word(REQ_GET, '0, '0, 63'd0, '0);
    send_word(REQ_GET, '0, '0, Max63, '0);
    send_word(REQ_APPLY, '0, '0, 63'd1, '0);
    send_word(REQ_COMMIT, '0, '0, 63'd1, '0);
    send_word(REQ_COMMIT, '0, '0, 63'd2, '0);
    send_word(REQ_COMMIT, '0, '0, 63'd99, '0);
    send_word(REQ_APPLY, '0, '0, 63'd1, '0);
    send_word(REQ_APPLY, '0, '0, 63'd99, '0);
    send_word(REQ_GET, '0, '0, 63'd1, '0);
    send_word(REQ_REPL, '0, '0, 63'd0, '0);
    send_word(REQ_REPL, '0, '0, Max63, '0);
    send_word(REQ_TOTALS, '0, '0, 63'd0, '0);
    send_word(REQ_TOTALS, '0, '0, 63'd1, '0);
    send_word(REQ_TOTALS, '0, '0, 63'd2, '0);
    send_word(REQ_TOTALS, '0, '0, 63'd3, '0);
    send_word(REQ_TOTALS, '0, '0, Max63, '0);
    send_word(REQ_CLEAN, '0, '0, 63'd2, '0);
    send_word(REQ_GET, '0, '0, 63'd1, '0);
    send_word(REQ_RESET, '0, '0, '0, '0);
    drain();

    // Zero limit admits only empty payloads; the top limit admits any.
    write_limit(16'd0);
    send_word(REQ_APPEND, rand63(), 16'd0, '0, rand63());
    send_word(REQ_APPEND, rand63(), 16'd1, '0, rand63());
    drain();
    write_limit(16'hFFFF);
    send_word(REQ_APPEND, rand63(), 16'hFFFF, '0, rand63());

    // Build a log of forty entries back to back, scan it whole, then compact
    // it down to a handful of entries.
    send_word(REQ_RESET, '0, '0, '0, '0);
    for (int i = 0; i < 40; i++) send_word(REQ_APPEND, rand63(), 16'($urandom), '0, rand63());
    send_word(REQ_GET, '0, '0, 63'd40, '0);
    send_word(REQ_COMMIT, '0, '0, 63'd40, '0);
    send_word(REQ_REPL, '0, '0, 63'd20, '0);
    send_word(REQ_CLEAN, '0, '0, 63'd35, '0);
    newest_guess = 63'd40;
    drain();

    // Random phases, each under its own payload limit.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_limit(16'd1024);
        1: write_limit(16'($urandom));
        2: write_limit(16'hFFFF);
        default: write_limit(16'd300);
      endcase
      for (int i = 0; i < 125; i++) send_random();
      drain();
    end

    idle_gap(1);
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (50) @(posedge clk);

    $display("Checked %0d result words over %0d payload limit settings,", words_checked,
             settings_used + 1);
    $display("including compaction, size limits and every request kind.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failing words", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- consensus_log_table.f -----
rtl/clt_pkg.sv
rtl/clt_ram.sv
rtl/consensus_log_table.sv
rtl/clt_checker.sv
bench/clt_checker.sv
bench/tb_consensus_log_table.sv
